// ===== design/pcm16_gain_scaler_assert.svh =====
// Assertion macros shared by the gain scaler RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef PCM16_GAIN_SCALER_ASSERT_SVH
`define PCM16_GAIN_SCALER_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define PGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define PGS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/pgs_pkg.sv =====
// Shared types, constants and the divider step for the PCM gain scaler.
// No dependencies; imported by pcm16_gain_scaler.
package pgs_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 10;
  localparam int FACTOR_WIDTH  = 15;
  localparam int MODE_WIDTH    = 2;
  // Magnitude of sample * 2^FRACTION_BITS, which reaches 2^25 and needs 26 bits.
  localparam int MAG_WIDTH     = SAMPLE_WIDTH + FRACTION_BITS;
  // One restoring-division stage per quotient bit.
  localparam int DIV_STEPS     = MAG_WIDTH;
  localparam int PROD_WIDTH    = SAMPLE_WIDTH + 1 + FACTOR_WIDTH;

  localparam logic [MAG_WIDTH-1:0] POS_LIMIT = MAG_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic [MAG_WIDTH-1:0] NEG_LIMIT = MAG_WIDTH'(1 << (SAMPLE_WIDTH - 1));
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_BYPASS    = 2'd0,
    MODE_AMPLIFY   = 2'd1,
    MODE_ATTENUATE = 2'd2
  } gain_mode_t;

  typedef enum logic {
    REG_GAIN_MODE   = 1'b0,
    REG_GAIN_FACTOR = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           last_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
    logic                           last_out;
  } result_t;

  // One divider stage: sign, packet end, divide flag, partial remainder and a
  // shift register that trades dividend bits for quotient bits.
  typedef struct packed {
    logic                    neg;
    logic                    last;
    logic                    div;
    logic [FACTOR_WIDTH-1:0] rem;
    logic [MAG_WIDTH-1:0]    aq;
  } pipe_t;

  // Produces one quotient bit. Items that do not divide pass unchanged.
  function automatic pipe_t div_step(pipe_t p, logic [FACTOR_WIDTH-1:0] d);
    logic [FACTOR_WIDTH:0] trial;
    logic [FACTOR_WIDTH:0] diff;
    pipe_t                 n;
    n     = p;
    trial = {p.rem, p.aq[MAG_WIDTH-1]};
    diff  = trial - {1'b0, d};
    if (p.div) begin
      n.aq = {p.aq[MAG_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        n.rem   = diff[FACTOR_WIDTH-1:0];
        n.aq[0] = 1'b1;
      end else begin
        n.rem = trial[FACTOR_WIDTH-1:0];
      end
    end
    return n;
  endfunction

endpackage

// ===== design/pcm16_gain_scaler.sv =====
// Top level of the PCM gain scaler: bypass, Q10 amplify, Q10 attenuate, saturation.
// Depends on pgs_pkg and pcm16_gain_scaler_assert.svh.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid, sample_stall   sample (sample_in, last_in)
//  result    out        result_valid, result_stall   result (sample_out, clipped, last_out)
//  config    in         cfg_we                       cfg_index, cfg_data
//
// One beat enters per cycle unless the output is stalled; each beat passes 29 register stages
// on its way to the output register: decode, multiply, 26 restoring-division stages
// (one quotient bit each) and the saturation stage. The division stages set the latency.
// Reset is synchronous and clears all valid bits and both gain registers.
// A stalled output beat freezes the whole pipeline and stalls the input side.
`include "pcm16_gain_scaler_assert.svh"

module pcm16_gain_scaler
  import pgs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  sample_t                 sample,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result,
  input  logic                    cfg_we,
  input  reg_index_t              cfg_index,
  input  logic [FACTOR_WIDTH-1:0] cfg_data
);

  gain_mode_t              gain_mode;
  logic [FACTOR_WIDTH-1:0] gain_factor;

  logic                    adv;
  logic                    take;

  // Decode stage.
  logic                    a_vld;
  logic                    a_neg;
  logic                    a_last;
  op_t                     a_op;
  logic [SAMPLE_WIDTH:0]   a_mag;

  logic [SAMPLE_WIDTH:0]   in_mag;
  op_t                     in_op;
  logic [PROD_WIDTH-1:0]   prod;
  pipe_t                   b_next;

  // Stage 0 holds the product, dividend or bypass magnitude; stages 1..DIV_STEPS divide.
  logic [DIV_STEPS:0]      vld;
  pipe_t                   st [DIV_STEPS+1];

  logic [MAG_WIDTH-1:0]    q;
  logic [SAMPLE_WIDTH-1:0] q_low;
  result_t                 result_next;

  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;
  assign take         = sample_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode   <= MODE_BYPASS;
      gain_factor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_MODE:   gain_mode   <= gain_mode_t'(cfg_data[MODE_WIDTH-1:0]);
        REG_GAIN_FACTOR: gain_factor <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    in_mag = sample.sample_in[SAMPLE_WIDTH-1]
           ? (~{1'b1, sample.sample_in} + 1'b1)
           : {1'b0, sample.sample_in};
    in_op = OP_PASS;
    if (gain_factor != '0) begin
      case (gain_mode)
        MODE_AMPLIFY:   in_op = OP_MUL;
        MODE_ATTENUATE: in_op = OP_DIV;
        default:        in_op = OP_PASS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg  <= sample.sample_in[SAMPLE_WIDTH-1];
      a_last <= sample.last_in;
      a_op   <= in_op;
      a_mag  <= in_mag;
    end
  end

  // Truncation toward zero is truncation of the magnitude, so both scaling
  // paths work on |sample| and put the sign back at the end.
  always_comb begin
    prod        = PROD_WIDTH'(a_mag) * PROD_WIDTH'(gain_factor);
    b_next.neg  = a_neg;
    b_next.last = a_last;
    b_next.div  = (a_op == OP_DIV);
    b_next.rem  = '0;
    case (a_op)
      OP_MUL:  b_next.aq = MAG_WIDTH'(prod >> FRACTION_BITS);
      OP_DIV:  b_next.aq = MAG_WIDTH'(a_mag) << FRACTION_BITS;
      default: b_next.aq = MAG_WIDTH'(a_mag);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STEPS-1:0], a_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= b_next;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= div_step(st[k-1], gain_factor);
      end
    end
  end

  always_comb begin
    q                    = st[DIV_STEPS].aq;
    q_low                = q[SAMPLE_WIDTH-1:0];
    result_next.last_out = st[DIV_STEPS].last;
    result_next.clipped  = 1'b0;
    if (st[DIV_STEPS].neg) begin
      if (q > NEG_LIMIT) begin
        result_next.sample_out = SAMPLE_MIN;
        result_next.clipped    = 1'b1;
      end else begin
        result_next.sample_out = ~q_low + 1'b1;
      end
    end else begin
      if (q > POS_LIMIT) begin
        result_next.sample_out = SAMPLE_MAX;
        result_next.clipped    = 1'b1;
      end else begin
        result_next.sample_out = q_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  `PGS_ASSERT(a_clip_at_bound, result_valid && result.clipped |->
    (result.sample_out == SAMPLE_MAX || result.sample_out == SAMPLE_MIN),
    "clipped beat does not hold a saturation bound")
  `PGS_ASSERT(a_pipe_frozen, !adv |=> $stable(vld) && $stable(a_vld),
    "pipeline valid bits moved during an output stall")
  `PGS_ASSERT(a_result_source, $rose(result_valid) |-> $past(vld[DIV_STEPS]),
    "result appeared without a beat in the last divider stage")
  `PGS_NEVER(a_no_div_on_zero, a_vld && a_op == OP_DIV && gain_factor == '0,
    "division scheduled with a zero factor")

endmodule

// ===== tb/sv/tb_pcm16_gain_scaler.sv =====
// Self-checking testbench for pcm16_gain_scaler: bypass, Q10 amplify, Q10 attenuate, saturation.
// Depends on pgs_pkg for the beat types, register indexes and gain modes.
// A predictor in this file computes every expected beat, and each output beat is checked in order.
module tb_pcm16_gain_scaler
  import pgs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int FLUSH_CYCLES  = 60;
  localparam int PHASE_COUNT   = 13;
  localparam int PHASE_SAMPLES = 100;
  localparam longint UNITY_Q   = longint'(1) << FRACTION_BITS;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  sample_t                 sample = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  result_t                 result;
  logic                    cfg_we = 1'b0;
  reg_index_t              cfg_index = REG_GAIN_MODE;
  logic [FACTOR_WIDTH-1:0] cfg_data = '0;

  // Copies of the gain registers as the block should hold them.
  logic [MODE_WIDTH-1:0]   gain_mode_q = '0;
  logic [FACTOR_WIDTH-1:0] gain_factor_q = '0;

  result_t scaled_queue[$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      steady = 1'b0;

  pcm16_gain_scaler i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit take_idle();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  function automatic sample_t mk_sample(int value, bit last);
    sample_t s;
    s.sample_in = SAMPLE_WIDTH'(value);
    s.last_in   = last;
    return s;
  endfunction

  function automatic result_t predict_scaled(sample_t s);
    result_t r;
    longint  x;
    longint  f;
    longint  q;
    x = longint'(s.sample_in);
    f = longint'(gain_factor_q);
    q = x;
    if (f != 0 && gain_mode_q == MODE_AMPLIFY) begin
      q = (x * f) / UNITY_Q;
    end else if (f != 0 && gain_mode_q == MODE_ATTENUATE) begin
      q = (x * UNITY_Q) / f;
    end
    r.clipped = 1'b0;
    if (q > longint'(SAMPLE_MAX)) begin
      q = longint'(SAMPLE_MAX);
      r.clipped = 1'b1;
    end else if (q < longint'(SAMPLE_MIN)) begin
      q = longint'(SAMPLE_MIN);
      r.clipped = 1'b1;
    end
    r.sample_out = SAMPLE_WIDTH'(q);
    r.last_out   = s.last_in;
    return r;
  endfunction

  // Called right after a rising edge; returns right after the edge that took the beat.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic send_sample(sample_t s);
    if (take_idle()) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while (take_idle());
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    scaled_queue.push_back(predict_scaled(s));
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (scaled_queue.size() != 0) @(posedge clk);
  endtask

  // The mode write may carry junk in the upper data bits; only the low two bits count.
  task automatic set_gain(logic [FACTOR_WIDTH-1:0] mode_data, logic [FACTOR_WIDTH-1:0] factor);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN_MODE;
    cfg_data  <= mode_data;
    @(posedge clk);
    cfg_index <= REG_GAIN_FACTOR;
    cfg_data  <= factor;
    @(posedge clk);
    cfg_we        <= 1'b0;
    gain_mode_q   = mode_data[MODE_WIDTH-1:0];
    gain_factor_q = factor;
  endtask

  always @(posedge clk) begin
    result_stall <= take_idle();
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (scaled_queue.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual %p", $time, result);
        errors++;
      end else begin
        want = scaled_queue.pop_front();
        if (result.sample_out !== want.sample_out) begin
          $display("%0t ns: sample_out expected %0d actual %0d",
                   $time, want.sample_out, result.sample_out);
          errors++;
        end
        if (result.clipped !== want.clipped) begin
          $display("%0t ns: clipped expected %b actual %b", $time, want.clipped, result.clipped);
          errors++;
        end
        if (result.last_out !== want.last_out) begin
          $display("%0t ns: last_out expected %b actual %b",
                   $time, want.last_out, result.last_out);
          errors++;
        end
      end
    end
  end

  // Both gain registers reset to zero, so samples must pass untouched.
  task automatic test_reset_defaults();
    send_sample(mk_sample(32767, 1'b0));
    send_sample(mk_sample(-32768, 1'b1));
  endtask

  task automatic test_directed_gain();
    set_gain({13'h1fff, MODE_AMPLIFY}, 15'd1024);
    send_sample(mk_sample(-32768, 1'b0));
    send_sample(mk_sample(32767, 1'b1));
    // Times sixteen: the samples land just inside, exactly on or just past the bounds.
    set_gain(15'(MODE_AMPLIFY), 15'd16384);
    send_sample(mk_sample(2047, 1'b0));
    send_sample(mk_sample(2048, 1'b0));
    send_sample(mk_sample(-2048, 1'b0));
    send_sample(mk_sample(-2049, 1'b1));
    // Negative products truncate toward zero, not toward minus infinity.
    set_gain(15'(MODE_AMPLIFY), 15'd1);
    send_sample(mk_sample(-1, 1'b0));
    send_sample(mk_sample(-1025, 1'b1));
    set_gain({13'h0aaa, MODE_ATTENUATE}, 15'd1);
    send_sample(mk_sample(32, 1'b0));
    send_sample(mk_sample(-32, 1'b0));
    send_sample(mk_sample(-33, 1'b1));
    set_gain(15'(MODE_ATTENUATE), 15'd3);
    send_sample(mk_sample(-7, 1'b1));
    // A factor above the nominal range is used as written.
    set_gain(15'(MODE_ATTENUATE), 15'h7fff);
    send_sample(mk_sample(32767, 1'b0));
    send_sample(mk_sample(-5, 1'b1));
    // The unused mode code behaves as bypass.
    set_gain(15'h7fff, 15'd5000);
    send_sample(mk_sample(-32768, 1'b1));
    // A zero factor forces bypass in both scaling modes.
    set_gain(15'(MODE_AMPLIFY), 15'd0);
    send_sample(mk_sample(32767, 1'b0));
    set_gain(15'(MODE_ATTENUATE), 15'd0);
    send_sample(mk_sample(-32768, 1'b1));
    set_gain({13'h1555, MODE_BYPASS}, 15'd2048);
    send_sample(mk_sample(12345, 1'b0));
  endtask

  function automatic logic [FACTOR_WIDTH-1:0] pick_factor();
    int unsigned pick;
    pick = $urandom_range(5);
    case (pick)
      0: begin
        case ($urandom_range(4))
          0: return 15'd0;
          1: return 15'd1;
          2: return 15'd1024;
          3: return 15'd16384;
          default: return 15'h7fff;
        endcase
      end
      1: return FACTOR_WIDTH'($urandom_range(1, 64));
      2: return FACTOR_WIDTH'($urandom_range(960, 1088));
      3: return FACTOR_WIDTH'($urandom_range(1, 16384));
      4: return FACTOR_WIDTH'($urandom_range(0, 32767));
      default: return FACTOR_WIDTH'($urandom_range(16385, 32767));
    endcase
  endfunction

  function automatic logic [MODE_WIDTH-1:0] pick_mode();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return MODE_BYPASS;
    end else if (pick == 1) begin
      return 2'd3;
    end else if (pick < 6) begin
      return MODE_AMPLIFY;
    end
    return MODE_ATTENUATE;
  endfunction

  function automatic sample_t pick_sample();
    sample_t     s;
    int unsigned pick;
    pick = $urandom_range(7);
    case (pick)
      0: begin
        case ($urandom_range(4))
          0: s.sample_in = SAMPLE_MIN;
          1: s.sample_in = SAMPLE_MAX;
          2: s.sample_in = '0;
          3: s.sample_in = '1;
          default: s.sample_in = 16'sd1;
        endcase
      end
      1: s.sample_in = SAMPLE_WIDTH'($urandom_range(0, 128) - 64);
      default: s.sample_in = SAMPLE_WIDTH'($urandom);
    endcase
    // Packets of about eight samples.
    s.last_in = ($urandom_range(7) == 0);
    return s;
  endfunction

  task automatic test_random_stream();
    logic [FACTOR_WIDTH-3:0] junk;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      junk = ($urandom_range(1) == 0) ? '0 : (FACTOR_WIDTH-2)'($urandom);
      set_gain({junk, pick_mode()}, pick_factor());
      // One phase runs with neither side idling.
      steady = (phase == PHASE_COUNT / 2);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        send_sample(pick_sample());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_gain();
    test_random_stream();
    wait_idle();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
